[rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/lcd4_pkg.sv]
// shared types and constants of the character lcd pin interface
package lcd4_pkg;

    localparam int ADDR_W = 7;
    localparam int CHAR_W = 8;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CHAR_W-1:0] t_char;

    // what the back part has to do for one transfer
    typedef enum logic [1:0] {
        K_EVENT = 2'd0,
        K_READ  = 2'd1,
        K_WRITE = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] PIN_RS = 3'd0;
    localparam logic [2:0] PIN_RW = 3'd1;
    localparam logic [2:0] PIN_E  = 3'd2;
    localparam logic [2:0] PIN_D4 = 3'd3;
    localparam logic [2:0] PIN_D5 = 3'd4;
    localparam logic [2:0] PIN_D6 = 3'd5;
    localparam logic [2:0] PIN_D7 = 3'd6;

    localparam t_char CHAR_SPACE = 8'h20;
    localparam t_char CMD_CLEAR  = 8'h01;
    localparam t_char CMD_HOME   = 8'h02;

    typedef struct packed {
        t_kind kind;
        t_addr addr;
        t_char data;
        t_addr cursor;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/char_lcd_4bit_pin_interface_unit.sv]
// character lcd 4-bit pin interface: top level
// path: an accepted transfer is written into the queue, then popped into the result register
// throughput: one transfer per cycle while the queue has room; o_ready drops when it is full
// clear: per-cell valid bits drop at once, cells then read as space
// reset: synchronous active low, cursor and nibble state to zero, all cells read as space
`include "assert_macros.svh"

module char_lcd_4bit_pin_interface_unit #(
    parameter int DISPLAY_CELLS = 80
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // pin event / read request channel
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_op,
    input  logic [2:0]      i_pin,
    input  logic            i_level,
    input  lcd4_pkg::t_addr i_read_addr,
    // result channel
    output logic            o_valid,
    input  logic            i_ready,
    output lcd4_pkg::t_char o_read_char,
    output lcd4_pkg::t_addr o_cursor_pos,
    output logic            o_char_written,
    output lcd4_pkg::t_addr o_write_addr,
    output lcd4_pkg::t_char o_write_char,
    output logic            o_display_cleared
);
    import lcd4_pkg::*;

    localparam logic [7:0] CELLS = 8'(DISPLAY_CELLS);

    t_q_status q_status;
    logic      push;
    t_cmd      push_cmd;
    logic      q_valid;
    logic      q_ready;
    t_cmd      q_cmd;

    // front: decodes pin events, owns rs, shift byte, nibble phase and cursor
    lcd4_front #(
        .DISPLAY_CELLS(DISPLAY_CELLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_pin      (i_pin),
        .i_level    (i_level),
        .i_read_addr(i_read_addr),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // queue lets the decoder run on while the result side stalls
    lcd4_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_status(q_status),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    // back: executes writes, reads and clears in order on the cell store
    lcd4_back #(
        .DISPLAY_CELLS(DISPLAY_CELLS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pop_valid      (q_valid),
        .o_pop_ready      (q_ready),
        .i_cmd            (q_cmd),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_read_char      (o_read_char),
        .o_cursor_pos     (o_cursor_pos),
        .o_char_written   (o_char_written),
        .o_write_addr     (o_write_addr),
        .o_write_char     (o_write_char),
        .o_display_cleared(o_display_cleared)
    );

    // no result may appear right after reset
    `ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_valid, "result valid right after reset")

    // cursor stays inside the display
    `ASSERT_RUN(a_cursor_range, o_valid |-> ({1'b0, o_cursor_pos} < CELLS), "cursor out of range")

    // a transfer into an idle pipe comes out through the queue and then the result register
    `ASSERT_RUN(a_idle_latency, push && q_status.empty && !o_valid |-> ##2 o_valid, "no result")

endmodule

[rtl/lcd4_front.sv]
// pin decoder: tracks rs, nibble shifter and cursor, classifies each transfer
module lcd4_front #(
    parameter int DISPLAY_CELLS = 80
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_op,
    input  logic [2:0]     i_pin,
    input  logic           i_level,
    input  lcd4_pkg::t_addr i_read_addr,
    input  lcd4_pkg::t_q_status i_q_status,
    output logic           o_push,
    output lcd4_pkg::t_cmd o_cmd
);
    import lcd4_pkg::*;

    localparam t_addr LAST_CELL = ADDR_W'(DISPLAY_CELLS - 1);

    logic  r_rs, n_rs;
    t_char r_shift, n_shift;
    logic  r_second, n_second;
    t_addr r_cursor, n_cursor;
    logic  accept;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        n_rs         = r_rs;
        n_shift      = r_shift;
        n_second     = r_second;
        n_cursor     = r_cursor;
        o_cmd.kind   = K_EVENT;
        o_cmd.addr   = '0;
        o_cmd.data   = '0;
        if (i_op == OP_READ) begin
            o_cmd.kind = K_READ;
            o_cmd.addr = i_read_addr;
        end else begin
            unique case (i_pin)
                PIN_RS: n_rs = i_level;
                PIN_RW: ; // no effect
                PIN_E: begin
                    if (i_level) begin
                        if (r_second) begin
                            if (r_rs) begin
                                o_cmd.kind = K_WRITE;
                                o_cmd.addr = r_cursor;
                                o_cmd.data = r_shift;
                                n_cursor   = (r_cursor == LAST_CELL) ? '0
                                                                     : r_cursor + t_addr'(1);
                            end else if (r_shift == CMD_CLEAR) begin
                                o_cmd.kind = K_CLEAR;
                                n_cursor   = '0;
                            end else if (r_shift == CMD_HOME) begin
                                n_cursor = '0;
                            end
                        end
                        n_second = !r_second;
                    end else begin
                        n_shift = {r_shift[3:0], r_shift[3:0]};
                    end
                end
                PIN_D4, PIN_D5, PIN_D6, PIN_D7: n_shift[2'(i_pin - PIN_D4)] = i_level;
                default: ;
            endcase
        end
        o_cmd.cursor = n_cursor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs     <= 1'b0;
            r_shift  <= '0;
            r_second <= 1'b0;
            r_cursor <= '0;
        end else if (accept) begin
            r_rs     <= n_rs;
            r_shift  <= n_shift;
            r_second <= n_second;
            r_cursor <= n_cursor;
        end
    end

endmodule

[rtl/lcd4_queue.sv]
// two-entry command queue between decoder and cell store
module lcd4_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lcd4_pkg::t_cmd      i_cmd,
    output lcd4_pkg::t_q_status o_status,
    output logic                o_valid,
    input  logic                i_ready,
    output lcd4_pkg::t_cmd      o_cmd
);
    import lcd4_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_slot [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_status.full  = (r_count == 2'(DEPTH));
    assign o_status.empty = (r_count == 2'd0);
    assign o_valid        = !o_status.empty;
    assign o_cmd          = r_slot[r_rd_ptr];
    assign pop            = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

[rtl/lcd4_back.sv]
// cell store with per-cell valid bits and the result register
module lcd4_back #(
    parameter int DISPLAY_CELLS = 80
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  lcd4_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output lcd4_pkg::t_char o_read_char,
    output lcd4_pkg::t_addr o_cursor_pos,
    output logic            o_char_written,
    output lcd4_pkg::t_addr o_write_addr,
    output lcd4_pkg::t_char o_write_char,
    output logic            o_display_cleared
);
    import lcd4_pkg::*;

    localparam int         IDX_W = $clog2(DISPLAY_CELLS);
    localparam logic [7:0] CELLS = 8'(DISPLAY_CELLS);

    t_char                    r_cells [DISPLAY_CELLS];
    logic [DISPLAY_CELLS-1:0] r_filled;
    t_char                    r_cell_q;
    logic                     r_hit;
    t_cmd                     r_cmd;
    logic                     r_out_valid;
    logic                     pop;
    logic [IDX_W-1:0]         idx;
    logic                     in_range;

    assign o_pop_ready = !r_out_valid || i_ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign idx         = i_cmd.addr[IDX_W-1:0];
    assign in_range    = {1'b0, i_cmd.addr} < CELLS;

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.kind == K_WRITE) begin
            r_cells[idx] <= i_cmd.data;
        end
        if (pop && i_cmd.kind == K_READ) begin
            r_cell_q <= r_cells[idx];
            r_hit    <= in_range && r_filled[idx];
        end
        if (pop) begin
            r_cmd <= i_cmd;
        end
    end

    // a cell never written since reset or clear reads as space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (pop && i_cmd.kind == K_CLEAR) begin
            r_filled <= '0;
        end else if (pop && i_cmd.kind == K_WRITE) begin
            r_filled[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_read_char       = (r_cmd.kind != K_READ) ? '0 : (r_hit ? r_cell_q : CHAR_SPACE);
    assign o_cursor_pos      = r_cmd.cursor;
    assign o_char_written    = (r_cmd.kind == K_WRITE);
    assign o_write_addr      = o_char_written ? r_cmd.addr : '0;
    assign o_write_char      = o_char_written ? r_cmd.data : '0;
    assign o_display_cleared = (r_cmd.kind == K_CLEAR);

endmodule
